// ===== hw/rtl/cipf_pkg.sv =====
// ----------------------------------------------------------------------------
// cipf_pkg
// Shared types, constants and the ident range table of the CSS input
// code point filter.
// ----------------------------------------------------------------------------
package cipf_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CP_W        = 21;
  localparam int unsigned MAX_RES     = 3;
  localparam int unsigned NUM_RANGES  = 15;

  localparam logic [CP_W-1:0] CP_REPL = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_LF   = 21'h00000A;
  localparam logic [CP_W-1:0] CP_CR   = 21'h00000D;
  localparam logic [CP_W-1:0] CP_FF   = 21'h00000C;
  localparam logic [CP_W-1:0] CP_NUL  = 21'h000000;

  localparam logic [7:0] CONT_LO = 8'h80;
  localparam logic [7:0] CONT_HI = 8'hBF;

  typedef struct packed {
    logic            eof;
    logic [CP_W-1:0] cp;
  } entry_t;

  typedef struct packed {
    logic [1:0]             cnt;
    entry_t [MAX_RES-1:0]   ent;
  } bundle_t;

  localparam logic [CP_W-1:0] RANGE_LO [NUM_RANGES] = '{
    21'h0000B7, 21'h0000C0, 21'h0000D8, 21'h0000F8, 21'h00037F,
    21'h00200C, 21'h00200D, 21'h00203F, 21'h002040, 21'h002070,
    21'h002C00, 21'h003001, 21'h00F900, 21'h00FDF0, 21'h010000
  };
  localparam logic [CP_W-1:0] RANGE_HI [NUM_RANGES] = '{
    21'h0000B7, 21'h0000D6, 21'h0000F6, 21'h00037D, 21'h001FFF,
    21'h00200C, 21'h00200D, 21'h00203F, 21'h002040, 21'h00218F,
    21'h002FEF, 21'h00D7FF, 21'h00FDCF, 21'h00FFFD, 21'h10FFFF
  };

  function automatic logic is_non_ascii(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (cp >= RANGE_LO[i] && cp <= RANGE_HI[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ===== hw/rtl/cipf_front.sv =====
// ----------------------------------------------------------------------------
// cipf_front
// UTF-8 decoder with replacement and newline/NUL filtering; turns one byte
// into a bundle of up to three code points.
// ----------------------------------------------------------------------------
module cipf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_byte,
  input  logic              in_end,
  input  logic              q_full,
  output logic              q_wr,
  output cipf_pkg::bundle_t q_data
);

  typedef enum logic [1:0] {
    SURR_NONE,
    SURR_LEAD,
    SURR_HELD
  } surr_t;

  logic [1:0]                 need_r, need_nxt;
  logic [1:0]                 seen_r, seen_nxt;
  logic [cipf_pkg::CP_W-1:0]  part_r, part_nxt;
  logic [7:0]                 lower_r, lower_nxt;
  logic [7:0]                 upper_r, upper_nxt;
  surr_t                      sp_r, sp_nxt;
  logic                       acr_r, acr_nxt;

  logic                       acc;

  logic                       ld_emit;
  logic [cipf_pkg::CP_W-1:0]  ld_cp;
  logic [1:0]                 ld_need;
  logic [cipf_pkg::CP_W-1:0]  ld_part;
  logic [7:0]                 ld_lower;
  logic [7:0]                 ld_upper;
  surr_t                      ld_sp;

  cipf_pkg::entry_t [cipf_pkg::MAX_RES-1:0] raw;
  logic [1:0]                 raw_n;
  logic                       prev_cr;
  logic                       drop;
  logic [cipf_pkg::CP_W-1:0]  shifted;
  logic [2:0]                 seen_inc;

  function automatic cipf_pkg::entry_t map_cp(input cipf_pkg::entry_t e);
    cipf_pkg::entry_t m;
    m = e;
    if (!e.eof) begin
      if (e.cp == cipf_pkg::CP_CR || e.cp == cipf_pkg::CP_FF) begin
        m.cp = cipf_pkg::CP_LF;
      end else if (e.cp == cipf_pkg::CP_NUL) begin
        m.cp = cipf_pkg::CP_REPL;
      end
    end
    return m;
  endfunction

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  // lead byte decode
  always_comb begin
    ld_emit  = 1'b0;
    ld_cp    = cipf_pkg::CP_REPL;
    ld_need  = 2'd0;
    ld_part  = '0;
    ld_lower = cipf_pkg::CONT_LO;
    ld_upper = cipf_pkg::CONT_HI;
    ld_sp    = SURR_NONE;
    if (in_byte < 8'h80) begin
      ld_emit = 1'b1;
      ld_cp   = {13'd0, in_byte};
    end else if (in_byte inside {[8'hC2:8'hDF]}) begin
      ld_need = 2'd1;
      ld_part = {16'd0, in_byte[4:0]};
    end else if (in_byte inside {[8'hE0:8'hEF]}) begin
      ld_need = 2'd2;
      ld_part = {17'd0, in_byte[3:0]};
      if (in_byte == 8'hE0) begin
        ld_lower = 8'hA0;
      end
      if (in_byte == 8'hED) begin
        ld_upper = 8'h9F;
        ld_sp    = SURR_LEAD;
      end
    end else if (in_byte inside {[8'hF0:8'hF4]}) begin
      ld_need = 2'd3;
      ld_part = {18'd0, in_byte[2:0]};
      if (in_byte == 8'hF0) begin
        ld_lower = 8'h90;
      end
      if (in_byte == 8'hF4) begin
        ld_upper = 8'h8F;
      end
    end else begin
      ld_emit = 1'b1;
    end
  end

  assign shifted  = {part_r[cipf_pkg::CP_W-7:0], in_byte[5:0]};
  assign seen_inc = {1'b0, seen_r} + 3'd1;

  // step
  always_comb begin
    need_nxt  = need_r;
    seen_nxt  = seen_r;
    part_nxt  = part_r;
    lower_nxt = lower_r;
    upper_nxt = upper_r;
    sp_nxt    = sp_r;
    raw       = '0;
    raw_n     = 2'd0;
    prev_cr   = acr_r;
    if (in_end) begin
      prev_cr   = 1'b0;
      need_nxt  = 2'd0;
      seen_nxt  = 2'd0;
      part_nxt  = '0;
      lower_nxt = cipf_pkg::CONT_LO;
      upper_nxt = cipf_pkg::CONT_HI;
      sp_nxt    = SURR_NONE;
      if (sp_r == SURR_HELD) begin
        raw[0].cp  = cipf_pkg::CP_REPL;
        raw[1].cp  = cipf_pkg::CP_REPL;
        raw[2].eof = 1'b1;
        raw_n      = 2'd3;
      end else if (need_r != 2'd0) begin
        raw[0].cp  = cipf_pkg::CP_REPL;
        raw[1].eof = 1'b1;
        raw_n      = 2'd2;
      end else begin
        raw[0].eof = 1'b1;
        raw_n      = 2'd1;
      end
    end else if (sp_r == SURR_HELD) begin
      raw[0].cp = cipf_pkg::CP_REPL;
      if (in_byte inside {[cipf_pkg::CONT_LO:cipf_pkg::CONT_HI]}) begin
        need_nxt  = 2'd0;
        seen_nxt  = 2'd0;
        part_nxt  = '0;
        lower_nxt = cipf_pkg::CONT_LO;
        upper_nxt = cipf_pkg::CONT_HI;
        sp_nxt    = SURR_NONE;
        raw_n     = 2'd1;
      end else begin
        need_nxt  = ld_need;
        seen_nxt  = 2'd0;
        part_nxt  = ld_part;
        lower_nxt = ld_lower;
        upper_nxt = ld_upper;
        sp_nxt    = ld_sp;
        raw[1].cp = cipf_pkg::CP_REPL;
        raw[2].cp = ld_cp;
        raw_n     = ld_emit ? 2'd3 : 2'd2;
      end
    end else if (need_r == 2'd0) begin
      need_nxt  = ld_need;
      seen_nxt  = 2'd0;
      part_nxt  = ld_part;
      lower_nxt = ld_lower;
      upper_nxt = ld_upper;
      sp_nxt    = ld_sp;
      raw[0].cp = ld_cp;
      raw_n     = ld_emit ? 2'd1 : 2'd0;
    end else if (in_byte < lower_r || in_byte > upper_r) begin
      if (sp_r == SURR_LEAD && seen_r == 2'd0 && in_byte inside {[8'hA0:8'hBF]}) begin
        // encoded surrogate: hold ED A0-BF
        need_nxt  = 2'd0;
        seen_nxt  = 2'd0;
        part_nxt  = '0;
        lower_nxt = cipf_pkg::CONT_LO;
        upper_nxt = cipf_pkg::CONT_HI;
        sp_nxt    = SURR_HELD;
      end else begin
        need_nxt  = ld_need;
        seen_nxt  = 2'd0;
        part_nxt  = ld_part;
        lower_nxt = ld_lower;
        upper_nxt = ld_upper;
        sp_nxt    = ld_sp;
        raw[0].cp = cipf_pkg::CP_REPL;
        raw[1].cp = ld_cp;
        raw_n     = ld_emit ? 2'd2 : 2'd1;
      end
    end else begin
      lower_nxt = cipf_pkg::CONT_LO;
      upper_nxt = cipf_pkg::CONT_HI;
      sp_nxt    = SURR_NONE;
      part_nxt  = shifted;
      seen_nxt  = seen_inc[1:0];
      if (seen_inc >= {1'b0, need_r}) begin
        need_nxt  = 2'd0;
        seen_nxt  = 2'd0;
        part_nxt  = '0;
        raw[0].cp = shifted;
        raw_n     = 2'd1;
      end
    end
  end

  // CRLF folding and code point substitution
  always_comb begin
    drop    = prev_cr && (raw_n != 2'd0) && !raw[0].eof && (raw[0].cp == cipf_pkg::CP_LF);
    acr_nxt = 1'b0;
    for (int i = 0; i < cipf_pkg::MAX_RES; i++) begin
      if (2'(i) < raw_n && !raw[i].eof && raw[i].cp == cipf_pkg::CP_CR) begin
        acr_nxt = 1'b1;
      end
    end
    q_data.cnt = raw_n - {1'b0, drop};
    for (int i = 0; i < cipf_pkg::MAX_RES; i++) begin
      q_data.ent[i] = map_cp(raw[i]);
    end
    if (drop) begin
      q_data.ent[0] = map_cp(raw[1]);
      q_data.ent[1] = map_cp(raw[2]);
      q_data.ent[2] = '0;
    end
    q_wr = acc && (q_data.cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r  <= 2'd0;
      seen_r  <= 2'd0;
      part_r  <= '0;
      lower_r <= cipf_pkg::CONT_LO;
      upper_r <= cipf_pkg::CONT_HI;
      sp_r    <= SURR_NONE;
      acr_r   <= 1'b0;
    end else if (acc) begin
      need_r  <= need_nxt;
      seen_r  <= seen_nxt;
      part_r  <= part_nxt;
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
      sp_r    <= sp_nxt;
      acr_r   <= acr_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_no_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (need_r == 2'd0) |-> (seen_r == 2'd0))
    else $error("continuation count set with no sequence open");
  a_held_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (sp_r == SURR_HELD) |-> (need_r == 2'd0 && lower_r == cipf_pkg::CONT_LO))
    else $error("held surrogate with an open sequence");
`endif

endmodule

// ===== hw/rtl/cipf_queue.sv =====
// ----------------------------------------------------------------------------
// cipf_queue
// Small FIFO of result bundles between decoder and output serializer.
// ----------------------------------------------------------------------------
module cipf_queue #(
  parameter int unsigned Depth = cipf_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  cipf_pkg::bundle_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output cipf_pkg::bundle_t rd_data,
  output logic              empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cipf_pkg::bundle_t mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;

  assign full    = (count_r == CntW'(Depth));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CntW'(wr_en) - CntW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (!full || rd_en))
    else $error("write into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("read from empty queue");
`endif

endmodule

// ===== hw/rtl/cipf_back.sv =====
// ----------------------------------------------------------------------------
// cipf_back
// Serializes queued bundles one code point per transfer, adds the ident
// flags and holds the result in the output register.
// ----------------------------------------------------------------------------
module cipf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cipf_pkg::bundle_t q_data,
  input  logic              q_empty,
  output logic              q_rd,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,
  output logic [3:0]        out_tuser,
  output logic              out_tlast
);

  logic [1:0]                idx_r, idx_nxt;
  logic                      valid_r, valid_nxt;
  logic [cipf_pkg::CP_W-1:0] cp_r;
  logic                      eof_r, st_r, id_r, na_r, last_r;

  logic                      load;
  logic                      is_last;
  cipf_pkg::entry_t          ent;
  logic                      na, st, id;

  assign load    = !q_empty && (!valid_r || out_tready);
  assign ent     = q_data.ent[idx_r];
  assign is_last = (idx_r == q_data.cnt - 2'd1);
  assign q_rd    = load && is_last;

  always_comb begin
    na = !ent.eof && cipf_pkg::is_non_ascii(ent.cp);
    st = !ent.eof && ((ent.cp inside {[21'h41:21'h5A], [21'h61:21'h7A]}) ||
                      ent.cp == 21'h5F || na);
    id = !ent.eof && (st || (ent.cp inside {[21'h30:21'h39]}) || ent.cp == 21'h2D);
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = is_last ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= ent.eof ? '0 : ent.cp;
      eof_r  <= ent.eof;
      st_r   <= st;
      id_r   <= id;
      na_r   <= na;
      last_r <= is_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'd0, cp_r};
  assign out_tuser  = {na_r, id_r, st_r, eof_r};
  assign out_tlast  = last_r;

`ifndef SYNTHESIS
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (idx_r < q_data.cnt))
    else $error("serializer index beyond bundle");
`endif

endmodule

// ===== hw/rtl/css_input_code_point_filter_top.sv =====
// ----------------------------------------------------------------------------
// css_input_code_point_filter_top
// CSS input code point filter: UTF-8 decode with replacement, newline
// folding and ident classification of a stylesheet byte stream.
//
// Input channel: one source byte per transfer on in_tdata; in_tlast high
// marks the end of the text (data ignored), which flushes any open
// sequence and yields an EOF result. Output channel: one code point per
// transfer, with is_eof and ident flags on out_tuser and out_tlast high on
// the final result caused by an input byte. Bytes that complete no code
// point (and LF after CR) give no output.
// A result passes the bundle queue and then the output register.
// Throughput: one byte per clock while the queue is not full; a byte
// with two or three results leaves as that many transfers of the single
// output register. A bundle queue of QueueDepth entries decouples the
// decoder from the output, so in_tready drops only when it fills.
// Reset (rst_n low, synchronous) empties the queue and returns the
// decoder to its idle state. When the receiver stalls the output holds
// and input keeps flowing until the queue is full.
// ----------------------------------------------------------------------------
module css_input_code_point_filter_top #(
  parameter int unsigned QueueDepth = cipf_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic [3:0]  out_tuser,  // [0] is_eof, [1] ident_start, [2] ident_char,
                                  // [3] intl_ident
  output logic        out_tlast   // last
);

  logic              q_wr;
  logic              q_rd;
  logic              q_full;
  logic              q_empty;
  cipf_pkg::bundle_t q_wdata;
  cipf_pkg::bundle_t q_rdata;

  cipf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_end    (in_tlast),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_data    (q_wdata)
  );

  cipf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  cipf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_rdata),
    .q_empty    (q_empty),
    .q_rd       (q_rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
